[rtl/tem_pkg.sv]
// shared constants, types and codes for the touch event mapper
package tem_pkg;

    localparam int COORD_RANGE = 4096;
    localparam int COORD_SHIFT = $clog2(COORD_RANGE);

    localparam int CMD_W     = 3;
    localparam int VAL_W     = 16;
    localparam int PANEL_W   = 12;
    localparam int VIEW_W    = 16;
    localparam int ID_W      = 32;
    localparam int KIND_W    = 2;
    localparam int CODE_W    = 3;
    localparam int CFG_IDX_W = 4;

    localparam int CF_W     = VAL_W + PANEL_W;
    localparam int SCALED_W = CF_W - COORD_SHIFT;
    localparam int MUL_A_W  = 20;
    localparam int MUL_B_W  = CF_W;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    localparam int DIV_NUM_W     = PROD_W;
    localparam int DIV_DEN_W     = VIEW_W;
    localparam int DIV_BITS_STEP = 4;
    localparam int DIV_CYCLES    = DIV_NUM_W / DIV_BITS_STEP;
    localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

    localparam logic [CMD_W-1:0] CMD_MOVE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PRESS   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESIZE  = 3'd3;

    localparam logic [KIND_W-1:0] KIND_ABS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_KEY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SYN = 2'd2;

    localparam logic [CODE_W-1:0] CODE_ID     = 3'd0;
    localparam logic [CODE_W-1:0] CODE_X      = 3'd1;
    localparam logic [CODE_W-1:0] CODE_Y      = 3'd2;
    localparam logic [CODE_W-1:0] CODE_TOUCH  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_REPORT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 4'd1;

    localparam logic [ID_W-1:0]    ID_RELOAD          = 32'd97;
    localparam logic [ID_W-1:0]    ID_NONE            = 32'hffff_ffff;
    localparam logic [PANEL_W-1:0] PANEL_WIDTH_RESET  = 12'd1080;
    localparam logic [PANEL_W-1:0] PANEL_HEIGHT_RESET = 12'd2340;
    localparam logic [VIEW_W-1:0]  VIEW_WIDTH_RESET   = 16'd1080;
    localparam logic [VIEW_W-1:0]  VIEW_HEIGHT_RESET  = 16'd810;

    typedef struct packed {
        logic [PANEL_W-1:0] panel_width;
        logic [PANEL_W-1:0] panel_height;
    } panel_cfg_t;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [CODE_W-1:0] code;
        logic [ID_W-1:0]   value;
        logic              last;
    } event_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

[rtl/tem_in_if.sv]
// pointer command channel
interface tem_in_if
    import tem_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [VAL_W-1:0] x_value;
    logic [VAL_W-1:0] y_value;

    modport source (output valid, command, x_value, y_value, input ready);
    modport sink   (input valid, command, x_value, y_value, output ready);
endinterface

[rtl/tem_out_if.sv]
// touch event channel
interface tem_out_if
    import tem_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] event_kind;
    logic [CODE_W-1:0] event_code;
    logic [ID_W-1:0]   event_value;
    logic              last_event;

    modport source (output valid, event_kind, event_code, event_value, last_event,
                    input ready);
    modport sink   (input valid, event_kind, event_code, event_value, last_event,
                    output ready);
endinterface

[rtl/tem_cfg_if.sv]
// configuration write channel
interface tem_cfg_if
    import tem_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [PANEL_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/tem_div.sv]
// iterative restoring divider, several quotient bits per cycle
module tem_div
    import tem_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_NUM_W-1:0] work_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_NUM_W-1:0] work_next;
    logic [DIV_DEN_W-1:0] rem_next;

    always_comb
    begin
        logic [DIV_DEN_W:0] trial;
        work_next = work_reg;
        rem_next  = rem_reg;
        for (int i = 0; i < DIV_BITS_STEP; i++)
        begin
            trial     = {rem_next, work_next[DIV_NUM_W-1]};
            work_next = {work_next[DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next     = DIV_DEN_W'(trial - {1'b0, den_reg});
                work_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[DIV_DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                work_reg <= req.num;
                rem_reg  <= '0;
                den_reg  <= req.den;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                work_reg <= work_next;
                rem_reg  <= rem_next;
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // zero divisor yields zero
    assign rsp.done = done_reg;
    assign rsp.quot = (den_reg == '0) ? '0 : work_reg;

endmodule

[rtl/tem_seq.sv]
// command sequencer with shared multiplier, view and tracking state
module tem_seq
    import tem_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  panel_cfg_t       panel,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [CMD_W-1:0] command,
    input  logic [VAL_W-1:0] x_value,
    input  logic [VAL_W-1:0] y_value,
    output div_req_t         div_req,
    input  div_rsp_t         div_rsp,
    output event_t           evt,
    input  logic             evt_ready
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMIT_ID,
        ST_AX_SCALE,
        ST_AX_TMUL,
        ST_AX_TDIV,
        ST_AX_FMUL,
        ST_AX_FDIV,
        ST_EMIT_AX,
        ST_EMIT_TOUCH,
        ST_RS_MUL1,
        ST_RS_MUL2,
        ST_RS_CMP,
        ST_RS_DIV,
        ST_EMIT_SYNC
    } state_t;

    state_t              state_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [VAL_W-1:0]    x_reg;
    logic [VAL_W-1:0]    y_reg;
    logic                axis_reg;
    logic [ID_W-1:0]     id_reg;
    logic [VIEW_W-1:0]   vw_reg;
    logic [VIEW_W-1:0]   vh_reg;
    logic [SCALED_W-1:0] scaled_reg;
    logic [CF_W-1:0]     t_reg;
    logic [ID_W-1:0]     ax_val_reg;
    logic [CF_W-1:0]     prod1_reg;
    logic [CF_W-1:0]     prod2_reg;
    logic                rs_hi_reg;

    logic [VAL_W-1:0]    coord;
    logic [PANEL_W-1:0]  full;
    logic [PANEL_W-1:0]  other;
    logic [VIEW_W-1:0]   v_this;
    logic [VIEW_W-1:0]   v_other;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   prod;
    logic [ID_W-1:0]     id_inc;
    logic                accept;
    logic                evt_taken;

    assign coord   = axis_reg ? y_reg : x_reg;
    assign full    = axis_reg ? panel.panel_height : panel.panel_width;
    assign other   = axis_reg ? panel.panel_width : panel.panel_height;
    assign v_this  = axis_reg ? vh_reg : vw_reg;
    assign v_other = axis_reg ? vw_reg : vh_reg;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign evt_taken = evt.valid && evt_ready;
    assign id_inc    = id_reg + 1'b1;

    // shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_AX_SCALE:
            begin
                mul_a = MUL_A_W'(coord);
                mul_b = MUL_B_W'(full);
            end
            ST_AX_TMUL:
            begin
                mul_a = MUL_A_W'(v_this);
                mul_b = MUL_B_W'(other);
            end
            ST_AX_FMUL:
            begin
                mul_a = MUL_A_W'(scaled_reg);
                mul_b = t_reg;
            end
            ST_RS_MUL1:
            begin
                mul_a = MUL_A_W'(x_reg);
                mul_b = MUL_B_W'(panel.panel_height);
            end
            ST_RS_MUL2:
            begin
                mul_a = MUL_A_W'(y_reg);
                mul_b = MUL_B_W'(panel.panel_width);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = prod;
        div_req.den   = v_other;
        unique case (state_reg)
            ST_AX_TMUL:
            begin
                div_req.start = 1'b1;
                div_req.den   = v_other;
            end
            ST_AX_FMUL:
            begin
                div_req.start = 1'b1;
                div_req.den   = DIV_DEN_W'(full);
            end
            ST_RS_CMP:
            begin
                div_req.start = 1'b1;
                if (prod1_reg > prod2_reg)
                begin
                    div_req.num = DIV_NUM_W'(prod2_reg);
                    div_req.den = x_reg;
                end
                else
                begin
                    div_req.num = DIV_NUM_W'(prod1_reg);
                    div_req.den = y_reg;
                end
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        evt.valid = 1'b0;
        evt.kind  = KIND_ABS;
        evt.code  = CODE_ID;
        evt.value = '0;
        evt.last  = 1'b0;
        unique case (state_reg)
            ST_EMIT_ID:
            begin
                evt.valid = 1'b1;
                evt.value = id_reg;
            end
            ST_EMIT_AX:
            begin
                evt.valid = 1'b1;
                evt.code  = axis_reg ? CODE_Y : CODE_X;
                evt.value = ax_val_reg;
            end
            ST_EMIT_TOUCH:
            begin
                evt.valid = 1'b1;
                evt.kind  = KIND_KEY;
                evt.code  = CODE_TOUCH;
                evt.value = ID_W'(cmd_reg == CMD_PRESS);
            end
            ST_EMIT_SYNC:
            begin
                evt.valid = 1'b1;
                evt.kind  = KIND_SYN;
                evt.code  = CODE_REPORT;
                evt.last  = 1'b1;
            end
            default:
            begin
                evt.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            id_reg    <= ID_RELOAD;
            vw_reg    <= VIEW_WIDTH_RESET;
            vh_reg    <= VIEW_HEIGHT_RESET;
            axis_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg  <= command;
                        x_reg    <= x_value;
                        y_reg    <= y_value;
                        axis_reg <= 1'b0;
                        case (command)
                            CMD_MOVE:
                                state_reg <= ST_AX_SCALE;
                            CMD_PRESS:
                            begin
                                if (x_value == '0 && y_value == '0)
                                begin
                                    state_reg <= ST_EMIT_SYNC;
                                end
                                else
                                begin
                                    id_reg    <= (id_inc == ID_NONE) ? ID_RELOAD : id_inc;
                                    state_reg <= ST_EMIT_ID;
                                end
                            end
                            CMD_RELEASE:
                            begin
                                id_reg    <= ID_NONE;
                                state_reg <= ST_EMIT_ID;
                            end
                            CMD_RESIZE:
                            begin
                                if (x_value == '0 || y_value == '0)
                                begin
                                    state_reg <= ST_EMIT_SYNC;
                                end
                                else
                                begin
                                    state_reg <= ST_RS_MUL1;
                                end
                            end
                            default:
                                state_reg <= ST_EMIT_SYNC;
                        endcase
                    end
                end
                ST_EMIT_ID:
                begin
                    if (evt_taken)
                    begin
                        state_reg <= (cmd_reg == CMD_RELEASE) ? ST_EMIT_TOUCH : ST_AX_SCALE;
                    end
                end
                ST_AX_SCALE:
                begin
                    scaled_reg <= prod[COORD_SHIFT +: SCALED_W];
                    if (v_this >= VIEW_W'(full))
                    begin
                        ax_val_reg <= ID_W'(prod[COORD_SHIFT +: SCALED_W]);
                        state_reg  <= ST_EMIT_AX;
                    end
                    else
                    begin
                        state_reg <= ST_AX_TMUL;
                    end
                end
                ST_AX_TMUL:
                    state_reg <= ST_AX_TDIV;
                ST_AX_TDIV:
                begin
                    if (div_rsp.done)
                    begin
                        t_reg     <= div_rsp.quot[CF_W-1:0];
                        state_reg <= ST_AX_FMUL;
                    end
                end
                ST_AX_FMUL:
                    state_reg <= ST_AX_FDIV;
                ST_AX_FDIV:
                begin
                    if (div_rsp.done)
                    begin
                        ax_val_reg <= ID_W'(full >> 1) - ID_W'(t_reg >> 1)
                                      + div_rsp.quot[ID_W-1:0];
                        state_reg  <= ST_EMIT_AX;
                    end
                end
                ST_EMIT_AX:
                begin
                    if (evt_taken)
                    begin
                        if (!axis_reg)
                        begin
                            axis_reg  <= 1'b1;
                            state_reg <= ST_AX_SCALE;
                        end
                        else if (cmd_reg == CMD_PRESS)
                        begin
                            state_reg <= ST_EMIT_TOUCH;
                        end
                        else
                        begin
                            state_reg <= ST_EMIT_SYNC;
                        end
                    end
                end
                ST_EMIT_TOUCH:
                begin
                    if (evt_taken)
                    begin
                        state_reg <= ST_EMIT_SYNC;
                    end
                end
                ST_RS_MUL1:
                begin
                    prod1_reg <= prod[CF_W-1:0];
                    state_reg <= ST_RS_MUL2;
                end
                ST_RS_MUL2:
                begin
                    prod2_reg <= prod[CF_W-1:0];
                    state_reg <= ST_RS_CMP;
                end
                ST_RS_CMP:
                begin
                    rs_hi_reg <= (prod1_reg > prod2_reg);
                    state_reg <= ST_RS_DIV;
                end
                ST_RS_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        if (rs_hi_reg)
                        begin
                            vh_reg <= div_rsp.quot[VIEW_W-1:0];
                            vw_reg <= VIEW_W'(panel.panel_width);
                        end
                        else
                        begin
                            vw_reg <= div_rsp.quot[VIEW_W-1:0];
                            vh_reg <= VIEW_W'(panel.panel_height);
                        end
                        state_reg <= ST_EMIT_SYNC;
                    end
                end
                ST_EMIT_SYNC:
                begin
                    if (evt_taken)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[rtl/touch_event_mapper_core.sv]
// touch event mapper top level: configuration registers and event output stage
// other commands, empty resize and origin press emit only the sync event; release emits
// id, touch and sync; move emits both axes and sync, and press adds id and touch
// a letterboxed axis runs two passes of the shared divider, 4 quotient bits a cycle
// one pointer transaction at a time; the next is taken once its sync event leaves
// reset: panel 1080x2340, view 1080x810, tracking id 97, no event pending
module touch_event_mapper_core
    import tem_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    tem_in_if.sink     pointer,
    tem_out_if.source  events,
    tem_cfg_if.sink    cfg
);

    panel_cfg_t        panel_reg;
    logic              out_valid_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic [ID_W-1:0]   out_value_reg;
    logic              out_last_reg;

    event_t   evt;
    logic     evt_ready;
    div_req_t div_req;
    div_rsp_t div_rsp;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_reg.panel_width  <= PANEL_WIDTH_RESET;
            panel_reg.panel_height <= PANEL_HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_PANEL_WIDTH:  panel_reg.panel_width  <= cfg.data;
                REG_PANEL_HEIGHT: panel_reg.panel_height <= cfg.data;
                default:          ;
            endcase
        end
    end

    tem_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tem_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .panel     (panel_reg),
        .in_valid  (pointer.valid),
        .in_ready  (pointer.ready),
        .command   (pointer.command),
        .x_value   (pointer.x_value),
        .y_value   (pointer.y_value),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .evt       (evt),
        .evt_ready (evt_ready)
    );

    assign evt_ready = !out_valid_reg || events.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (evt_ready)
        begin
            out_valid_reg <= evt.valid;
            out_kind_reg  <= evt.kind;
            out_code_reg  <= evt.code;
            out_value_reg <= evt.value;
            out_last_reg  <= evt.last;
        end
    end

    assign events.valid       = out_valid_reg;
    assign events.event_kind  = out_kind_reg;
    assign events.event_code  = out_code_reg;
    assign events.event_value = out_value_reg;
    assign events.last_event  = out_last_reg;

endmodule

[rtl/tem_checker.sv]
// port-level checks for the touch event mapper
module tem_checker
    import tem_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [KIND_W-1:0] event_kind,
    input logic [CODE_W-1:0] event_code,
    input logic [ID_W-1:0]   event_value,
    input logic              last_event
);

    // stalled event holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind)
            && $stable(event_code) && $stable(event_value) && $stable(last_event))
        else $error("stalled event changed");

    // one transaction in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("pointer accepted while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_event |-> event_kind == KIND_SYN && event_code == CODE_REPORT)
        else $error("closing event is not a sync report");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == KIND_SYN |-> last_event)
        else $error("sync event without closing mark");

endmodule

bind touch_event_mapper_core tem_checker u_tem_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (pointer.valid),
    .in_ready    (pointer.ready),
    .out_valid   (events.valid),
    .out_ready   (events.ready),
    .event_kind  (events.event_kind),
    .event_code  (events.event_code),
    .event_value (events.event_value),
    .last_event  (events.last_event)
);
